FILE: src/slrng_pkg.sv
package slrng_pkg;

  localparam int VAL_W = 31;
  localparam int MULT_W = 15;
  localparam int PROD_W = VAL_W + MULT_W;

  localparam logic [MULT_W-1:0] LEH_MULT = 15'd16807;
  localparam logic [VAL_W-1:0] LEH_MOD = 31'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] OUT_MAX = 31'd2147483389;
  localparam logic [VAL_W-1:0] SEED_ONE = 31'd1;
  localparam int WARMUP_EXTRA = 8;

  typedef logic [VAL_W-1:0] val_t;

endpackage

FILE: src/slrng_lehmer.sv
module slrng_lehmer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  slrng_pkg::val_t   x,
  output logic              done,
  output slrng_pkg::val_t   y
);
  import slrng_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic              v1_r;
  logic              done_r;
  val_t              y_r;
  logic [VAL_W:0]    fold;
  val_t              y_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      done_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= PROD_W'(x) * PROD_W'(LEH_MULT);
    end
    if (v1_r) begin
      y_r <= y_nxt;
    end
  end

  // 2^31 = 1 mod (2^31 - 1): fold high part onto low part, reduce once
  always_comb begin
    fold  = {1'b0, prod_r[VAL_W-1:0]} + (VAL_W+1)'(prod_r[PROD_W-1:VAL_W]);
    y_nxt = (fold >= {1'b0, LEH_MOD}) ? VAL_W'(fold - {1'b0, LEH_MOD}) : fold[VAL_W-1:0];
  end

  assign done = done_r;
  assign y    = y_r;

endmodule

FILE: src/slrng_slot_div.sv
module slrng_slot_div #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  slrng_pkg::val_t                    dividend,
  output logic                               done,
  output logic [$clog2(TABLE_ENTRIES)-1:0]   quotient
);
  import slrng_pkg::*;

  localparam int QW = $clog2(TABLE_ENTRIES);
  localparam int RCP_W = QW + 3;
  localparam int RCP_SH = 32;
  localparam int EP_W = VAL_W + RCP_W;
  localparam longint SLOT_DIV_L = 1 + 2147483646 / TABLE_ENTRIES;
  localparam longint RCP_L = (longint'(1) <<< RCP_SH) / SLOT_DIV_L;
  localparam logic [VAL_W-1:0] SLOT_DIV = VAL_W'(SLOT_DIV_L);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

  val_t            num_r;
  logic [QW-1:0]   est_r;
  val_t            back_r;
  logic [QW-1:0]   q_r;
  logic            v1_r;
  logic            v2_r;
  logic            done_r;
  logic [EP_W-1:0] est_prod;
  val_t            rem;

  assign est_prod = EP_W'(dividend) * EP_W'(RCP);
  assign rem      = num_r - back_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // reciprocal estimate is low by at most one; correct with one compare
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      est_r <= est_prod[RCP_SH +: QW];
    end
    if (v1_r) begin
      back_r <= VAL_W'(est_r) * SLOT_DIV;
    end
    if (v2_r) begin
      q_r <= est_r + QW'(rem >= SLOT_DIV);
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: src/slrng_table.sv
module slrng_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   wr_addr,
  input  slrng_pkg::val_t                    wr_data,
  input  logic                               rd_en,
  input  logic [$clog2(TABLE_ENTRIES)-1:0]   rd_addr,
  output slrng_pkg::val_t                    rd_data
);
  import slrng_pkg::*;

  val_t mem [TABLE_ENTRIES];
  val_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/shuffled_lehmer_uniform_rng.sv
// Shuffled Lehmer uniform generator: minimal standard Lehmer sequence
// (x' = 16807 x mod 2^31-1) behind a Bays-Durham shuffle table.
// Input channel in_valid/in_ready carries in_reseed; each beat yields
// exactly one beat on out_valid/out_ready carrying out_uniform_fraction,
// the deviate as a numerator over 2^31-1, clamped at 2147483389.
// cfg_wr_en/cfg_wr_data load the seed; write it only while idle.
// A draw runs from accept through the multiply/fold unit, the reciprocal
// slot divider, one table read and one output load before the next
// accept; the result beat is offered from the output register.
// Initialisation, on the first beat after reset or when in_reseed is high,
// adds TABLE_ENTRIES + 8 warm-up steps, each a pass of the multiply/fold
// unit, before the draw itself. One beat is in flight at a
// time. Synchronous reset clears the seed to 1 and marks the table as
// unfilled; no clearing pass is needed. A stalled receiver holds the
// result in the output register; the next beat is still accepted, but
// its result waits until that register drains.
module shuffled_lehmer_uniform_rng #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_reseed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output slrng_pkg::val_t         out_uniform_fraction,
  input  logic                    cfg_wr_en,
  input  slrng_pkg::val_t         cfg_wr_data
);
  import slrng_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + WARMUP_EXTRA);
  localparam logic [CW-1:0] INIT_LAST = CW'(TABLE_ENTRIES + WARMUP_EXTRA - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_GEN  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;

  logic [2:0]    state_r, state_nxt;
  val_t          seed_r;
  val_t          gen_r, gen_nxt;
  val_t          sout_r, sout_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] slot_r, slot_nxt;
  logic          out_valid_r, out_valid_nxt;
  val_t          out_data_r, out_data_nxt;

  val_t          seed_fix;
  logic          lm_start, lm_done;
  val_t          lm_x, lm_y;
  logic          dv_start, dv_done;
  logic [AW-1:0] dv_q;
  logic [AW-1:0] slot_fix;
  logic          tb_wr_en, tb_rd_en;
  logic [AW-1:0] tb_wr_addr;
  val_t          tb_wr_data, tb_rd_data;
  logic          accept;

  slrng_lehmer u_lehmer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lm_start),
    .x     (lm_x),
    .done  (lm_done),
    .y     (lm_y)
  );

  slrng_slot_div #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_slot_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (sout_r),
    .done     (dv_done),
    .quotient (dv_q)
  );

  slrng_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
    .clk     (clk),
    .wr_en   (tb_wr_en),
    .wr_addr (tb_wr_addr),
    .wr_data (tb_wr_data),
    .rd_en   (tb_rd_en),
    .rd_addr (slot_fix),
    .rd_data (tb_rd_data)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign seed_fix = (seed_r == '0 || seed_r == LEH_MOD) ? SEED_ONE : seed_r;
  assign slot_fix = ({1'b0, dv_q} >= (AW+1)'(TABLE_ENTRIES)) ? '0 : dv_q;

  always_comb begin
    state_nxt     = state_r;
    gen_nxt       = gen_r;
    sout_nxt      = sout_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    lm_start      = 1'b0;
    lm_x          = gen_r;
    dv_start      = 1'b0;
    tb_wr_en      = 1'b0;
    tb_wr_addr    = slot_r;
    tb_wr_data    = gen_r;
    tb_rd_en      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          lm_start = 1'b1;
          if (in_reseed || sout_r == '0) begin
            lm_x      = seed_fix;
            cnt_nxt   = INIT_LAST;
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_GEN;
          end
        end
      end
      S_INIT: begin
        if (lm_done) begin
          lm_start = 1'b1;
          lm_x     = lm_y;
          if (cnt_r < CW'(TABLE_ENTRIES)) begin
            tb_wr_en   = 1'b1;
            tb_wr_addr = cnt_r[AW-1:0];
            tb_wr_data = lm_y;
          end
          if (cnt_r == '0) begin
            sout_nxt  = lm_y;
            state_nxt = S_GEN;
          end else begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
      end
      S_GEN: begin
        if (lm_done) begin
          gen_nxt   = lm_y;
          dv_start  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (dv_done) begin
          tb_rd_en  = 1'b1;
          slot_nxt  = slot_fix;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (!out_valid_r || out_ready) begin
          tb_wr_en      = 1'b1;
          sout_nxt      = tb_rd_data;
          out_valid_nxt = 1'b1;
          out_data_nxt  = (tb_rd_data > OUT_MAX) ? OUT_MAX : tb_rd_data;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seed_r      <= SEED_ONE;
      gen_r       <= '0;
      sout_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gen_r       <= gen_nxt;
      sout_r      <= sout_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_uniform_fraction = out_data_r;

endmodule

FILE: src/slrng_checker.sv
module slrng_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input slrng_pkg::val_t out_uniform_fraction
);
  import slrng_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_uniform_fraction))
    else $error("result beat changed while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_uniform_fraction != '0) && (out_uniform_fraction <= OUT_MAX))
    else $error("deviate outside its range");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while a draw is in progress");

endmodule

bind shuffled_lehmer_uniform_rng slrng_checker u_slrng_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_uniform_fraction (out_uniform_fraction)
);
